// ----- rtl/vsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Vibrational state count package
// Shared widths, request codes, register indexes, controller states and divider types.
// ----------------------------------------------------------------------------
package vsc_pkg;

  // Count table geometry.
  localparam int unsigned GridSize = 1024;
  localparam int unsigned AddrW    = $clog2(GridSize);
  localparam int unsigned BinsW    = AddrW + 1;
  localparam int unsigned CountW   = 64;

  // Payload and register widths.
  localparam int unsigned OpW      = 2;
  localparam int unsigned FreqW    = 20;
  localparam int unsigned StepW    = 20;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 20;

  // Shift divider: dividend 2f + g, divisor 2g.
  localparam int unsigned DivW     = FreqW + 2;
  localparam int unsigned DivisorW = StepW + 1;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  // Reset values of the configuration registers.
  localparam logic [StepW-1:0] GridStepReset = StepW'(100);
  localparam logic [BinsW-1:0] BinsReset     = BinsW'(GridSize);

  // Request codes.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_GRID_STEP = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BINS      = 1'b1;

  // Controller states.
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_e;

  // Divider control and status.
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/vsc_if.sv -----
// ----------------------------------------------------------------------------
// Vibrational state count channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface vsc_in_if;
  import vsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [FreqW-1:0] frequency;
  logic [AddrW-1:0] bin_index;

  modport source (output valid, output op, output frequency, output bin_index,
                  input ready);
  modport sink   (input valid, input op, input frequency, input bin_index,
                  output ready);
endinterface

interface vsc_out_if;
  import vsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] state_count;
  logic [AddrW-1:0]  read_index;
  logic              overflowed;

  modport source (output valid, output state_count, output read_index,
                  output overflowed, input ready);
  modport sink   (input valid, input state_count, input read_index,
                  input overflowed, output ready);
endinterface

// ----- rtl/vibrational_state_count_top.sv -----
// ----------------------------------------------------------------------------
// Vibrational state count top level
// Beyer-Swinehart state count table held in a two-read, one-write RAM.
// ----------------------------------------------------------------------------
// A read result passes through the RAM read register, then the output register,
// or the holding stage while the output is stalled. A frequency request runs the
// shift divider, then walks bins in use minus shift, one RAM read-modify-write each.
// A clear request writes one RAM entry a cycle across the table; one request at a time.
// Reset: control and config registers return to their reset values, then a
// clearing pass runs through the RAM while no request is accepted.
module vibrational_state_count_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vsc_pkg::CfgDataW-1:0]  cfg_data_i,
  vsc_in_if.sink                        req_i,
  vsc_out_if.source                     rsp_o
);
  import vsc_pkg::*;

  // Configuration registers.
  logic [StepW-1:0] grid_step_q;
  logic [BinsW-1:0] bins_q;
  logic [BinsW-1:0] bins_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_step_q <= GridStepReset;
      bins_q      <= BinsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_STEP: grid_step_q <= cfg_data_i[StepW-1:0];
        CFG_BINS:      bins_q      <= cfg_data_i[BinsW-1:0];
        default:       ;
      endcase
    end
  end

  // Bins in use: zero counts as one, the top is limited to the table.
  always_comb begin
    bins_eff = bins_q;
    if (bins_q == '0) begin
      bins_eff = BinsW'(1);
    end else if (bins_q > BinsW'(GridSize)) begin
      bins_eff = BinsW'(GridSize);
    end
  end

  // Controller registers.
  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic              ovf_q, ovf_d;
  logic [AddrW-1:0]  shift_q, shift_d;
  logic [AddrW-1:0]  last_q, last_d;
  logic [AddrW-1:0]  e_q, e_d;
  logic              issue_q, issue_d;
  logic              p_valid_q, p_valid_d;
  logic [AddrW-1:0]  p_wa_q;
  logic              fwd_a_q, fwd_b_q;
  logic [CountW-1:0] fwd_data_q;
  logic [AddrW-1:0]  rd_idx_q;
  logic [AddrW-1:0]  rd_idx_d;

  // Output register and its holding stage.
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_count_q;
  logic [AddrW-1:0]  out_idx_q;
  logic              out_ovf_q;
  logic              out_load;
  logic [CountW-1:0] out_count_d;
  logic              out_ovf_d;
  logic [CountW-1:0] pend_count_q;
  logic              pend_ovf_q;
  logic              pend_load;

  // RAM ports.
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CountW-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr_a, ram_raddr_b;
  logic [CountW-1:0] ram_rdata_a, ram_rdata_b;

  // Divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              req_acc;
  logic              slot_free;
  logic [CountW-1:0] src_val, dst_val;
  logic [CountW:0]   sum;
  logic              sum_ovf;
  logic [AddrW-1:0]  e_plus_s;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign e_plus_s    = e_q + shift_q;

  // Operand selection with forwarding of the write on the read edge.
  assign src_val = fwd_a_q ? fwd_data_q : ram_rdata_a;
  assign dst_val = fwd_b_q ? fwd_data_q : ram_rdata_b;
  assign sum     = {1'b0, dst_val} + {1'b0, src_val};
  assign sum_ovf = sum[CountW];

  // Shift division request: (2f + g) / (2g).
  assign div_req.start    = req_acc && (req_i.op == OP_ADD) && (grid_step_q != '0);
  assign div_req.dividend = {1'b0, req_i.frequency, 1'b0} + DivW'(grid_step_q);
  assign div_req.divisor  = {grid_step_q, 1'b0};

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ovf_d       = ovf_q;
    shift_d     = shift_q;
    last_d      = last_q;
    e_d         = e_q;
    issue_d     = issue_q;
    p_valid_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = p_wa_q;
    ram_wdata   = sum_ovf ? {CountW{1'b1}} : sum[CountW-1:0];
    ram_raddr_a = e_q;
    ram_raddr_b = e_plus_s;
    out_load    = 1'b0;
    pend_load   = 1'b0;
    out_count_d = ram_rdata_a;
    out_ovf_d   = ovf_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? CountW'(1) : '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(GridSize - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr_a = req_i.bin_index;
        if (req_acc) begin
          unique case (req_i.op)
            OP_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
              ovf_d   = 1'b0;
            end
            OP_ADD: begin
              if (grid_step_q != '0) begin
                state_d = ST_DIV;
              end
            end
            OP_READ: begin
              state_d  = ST_READ;
              rd_idx_d = req_i.bin_index;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= DivW'(bins_eff)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_WALK;
            shift_d = div_rsp.quotient[AddrW-1:0];
            last_d  = AddrW'(bins_eff - BinsW'(div_rsp.quotient[AddrW-1:0]) - 1'b1);
            e_d     = '0;
            issue_d = 1'b1;
          end
        end
      end
      ST_WALK: begin
        // Issue stage: read source e and destination e + shift.
        if (issue_q) begin
          p_valid_d = 1'b1;
          if (e_q == last_q) begin
            issue_d = 1'b0;
          end else begin
            e_d = e_q + 1'b1;
          end
        end
        // Data stage: saturating add written back to the destination.
        if (p_valid_q) begin
          ram_we = 1'b1;
          if (sum_ovf) begin
            ovf_d = 1'b1;
          end
        end
        if (!issue_q && !p_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          pend_load = 1'b1;
          state_d   = ST_HOLD;
        end
      end
      ST_HOLD: begin
        out_count_d = pend_count_q;
        out_ovf_d   = pend_ovf_q;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ovf_q       <= 1'b0;
      issue_q     <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_a_q     <= 1'b0;
      fwd_b_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ovf_q       <= ovf_d;
      issue_q     <= issue_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
      fwd_a_q     <= ram_we && (ram_waddr == ram_raddr_a);
      fwd_b_q     <= ram_we && (ram_waddr == ram_raddr_b);
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    last_q     <= last_d;
    e_q        <= e_d;
    p_wa_q     <= e_plus_s;
    fwd_data_q <= ram_wdata;
    rd_idx_q   <= rd_idx_d;
    if (pend_load) begin
      pend_count_q <= ram_rdata_a;
      pend_ovf_q   <= ovf_q;
    end
    if (out_load) begin
      out_count_q <= out_count_d;
      out_ovf_q   <= out_ovf_d;
      out_idx_q   <= rd_idx_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.state_count = out_count_q;
  assign rsp_o.read_index  = out_idx_q;
  assign rsp_o.overflowed  = out_ovf_q;

  // Count table storage.
  vsc_ram #(
    .Depth (GridSize),
    .Width (CountW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // Bin shift divider.
  vsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

// ----- rtl/vsc_ram.sv -----
// ----------------------------------------------------------------------------
// Vibrational state count RAM
// One write port and two synchronous read ports with registered data.
// ----------------------------------------------------------------------------
module vsc_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports return the contents before a write on the same edge.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/vsc_div.sv -----
// ----------------------------------------------------------------------------
// Vibrational state count shift divider
// Restoring divider, one quotient bit per cycle, for the bin shift.
// ----------------------------------------------------------------------------
module vsc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsc_pkg::div_req_t req_i,
  output vsc_pkg::div_rsp_t rsp_o
);
  import vsc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] dsr_q, dsr_d;
  logic [DivW-1:0]     trial;
  logic                fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q[DivW-2:0], quo_q[DivW-1]};
  assign fits  = trial >= DivW'(dsr_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? (trial - DivW'(dsr_q)) : trial;
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Vibrational state count testbench
// Drives register writes and clear, frequency, read and ignored requests into the
// state count block under random sender and receiver idling, and checks every bin
// read against a shadow copy of the count table kept beside the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsc_pkg::*;

  localparam int unsigned SettleCycles   = 1200;
  localparam int unsigned CycleLimit     = 3000000;
  localparam int unsigned NumSettings    = 12;
  localparam int unsigned RandPerSetting = 31;
  localparam int unsigned SatDoublings   = 66;

  typedef struct packed {
    op_e              op;
    logic [FreqW-1:0] frequency;
    logic [AddrW-1:0] bin_index;
  } request_t;

  typedef struct packed {
    logic [CountW-1:0] state_count;
    logic [AddrW-1:0]  read_index;
    logic              overflowed;
  } bin_read_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  vsc_in_if  req_if ();
  vsc_out_if rsp_if ();

  vibrational_state_count_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Requests waiting to be driven, and bin reads waiting for their result.
  request_t  request_q[$];
  bin_read_t expected_bins_q[$];
  request_t  next_req;

  // Shadow copy of the block's state and registers.
  logic [CountW-1:0] shadow_counts [GridSize];
  logic              shadow_overflow;
  logic [StepW-1:0]  shadow_step;
  logic [BinsW-1:0]  shadow_bins;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  int unsigned step_set [NumSettings];
  int unsigned bins_set [NumSettings];

  // Bins in use as the block takes them: zero counts as one, the top is capped.
  function automatic longint unsigned active_bins();
    longint unsigned n;
    n = shadow_bins;
    if (n == 0) n = 1;
    if (n > GridSize) n = GridSize;
    return n;
  endfunction

  function automatic void shadow_clear();
    for (int i = 0; i < GridSize; i++) shadow_counts[i] = '0;
    shadow_counts[0] = 1;
    shadow_overflow  = 1'b0;
  endfunction

  // Ascending in-place walk: each bin adds into the one a shift above it.
  function automatic void shadow_add_frequency(logic [FreqW-1:0] freq);
    longint unsigned n;
    longint unsigned g;
    longint unsigned shift;
    logic [CountW:0] sum;
    n = active_bins();
    g = shadow_step;
    if (g == 0) return;
    shift = (2 * longint'(freq) + g) / (2 * g);
    if (shift >= n) return;
    for (longint unsigned e = 0; e + shift < n; e++) begin
      sum = {1'b0, shadow_counts[e + shift]} + {1'b0, shadow_counts[e]};
      if (sum[CountW]) begin
        shadow_overflow = 1'b1;
        shadow_counts[e + shift] = '1;
      end else begin
        shadow_counts[e + shift] = sum[CountW-1:0];
      end
    end
  endfunction

  // Updates the shadow state for one accepted request.
  function automatic void apply_request(op_e op, logic [FreqW-1:0] freq,
                                        logic [AddrW-1:0] idx);
    bin_read_t rd;
    case (op)
      OP_CLEAR: shadow_clear();
      OP_ADD:   shadow_add_frequency(freq);
      OP_READ: begin
        rd.state_count = shadow_counts[idx];
        rd.read_index  = idx;
        rd.overflowed  = shadow_overflow;
        expected_bins_q = {expected_bins_q, rd};
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_request(op_e op, logic [FreqW-1:0] freq,
                                        logic [AddrW-1:0] idx);
    request_t r;
    r.op        = op;
    r.frequency = freq;
    r.bin_index = idx;
    request_q = {request_q, r};
  endfunction

  // A frequency whose shift rounds to zero under the current grid step.
  function automatic logic [FreqW-1:0] zero_shift_frequency();
    if (shadow_step == 0) return FreqW'($urandom_range(32'hFFFFF, 0));
    return FreqW'($urandom_range((shadow_step - 1) / 2, 0));
  endfunction

  // Frequencies mostly land on or next to the rounding points of shifts up to the bins in use.
  function automatic logic [FreqW-1:0] pick_frequency();
    longint unsigned g;
    longint unsigned f;
    g = shadow_step;
    if (g == 0 || $urandom_range(3) == 0) return FreqW'($urandom_range(32'hFFFFF, 0));
    f = longint'($urandom_range(active_bins(), 0)) * g;
    case ($urandom_range(4))
      0: f = f + g / 2;
      1: f = f + (g - 1) / 2;
      2: f = (f >= g / 2) ? f - g / 2 : 0;
      3: f = (f >= (g + 1) / 2) ? f - (g + 1) / 2 : 0;
      default: f = f + $urandom_range(g - 1, 0);
    endcase
    if (f > 64'hFFFFF) f = 64'hFFFFF;
    return FreqW'(f);
  endfunction

  // Reads mostly fall inside the bins in use, the rest anywhere in the table.
  function automatic logic [AddrW-1:0] pick_bin();
    if ($urandom_range(9) < 7) return AddrW'($urandom_range(active_bins() - 1, 0));
    return AddrW'($urandom_range(GridSize - 1, 0));
  endfunction

  // Register write, mirrored into the shadow registers at the writing edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_STEP) shadow_step = data[StepW-1:0];
    else shadow_bins = data[BinsW-1:0];
  endtask

  // Waits until every request is taken and every read has returned, then lets
  // a clear or a full walk that gives no result run out.
  task automatic drain();
    while (request_q.size() != 0 || req_if.valid || expected_bins_q.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Known values on every input from time zero.
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_GRID_STEP;
    cfg_data         = '0;
    req_if.valid     = 1'b0;
    req_if.op        = OP_NONE;
    req_if.frequency = '0;
    req_if.bin_index = '0;
    rsp_if.ready     = 1'b0;
  end

  // Request driver: holds a request until it is taken, then applies it to the
  // shadow state at the accepting edge.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid     <= 1'b0;
      req_if.op        <= OP_NONE;
      req_if.frequency <= '0;
      req_if.bin_index <= '0;
    end else begin
      if (req_if.valid && req_if.ready)
        apply_request(op_e'(req_if.op), req_if.frequency, req_if.bin_index);
      if (!req_if.valid || req_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = request_q.pop_front();
          req_if.valid     <= 1'b1;
          req_if.op        <= next_req.op;
          req_if.frequency <= next_req.frequency;
          req_if.bin_index <= next_req.bin_index;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each bin read with the oldest expectation.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_bins_q.size() == 0) begin
          $error("bin read result with none outstanding: index %0d count %0d",
                 rsp_if.read_index, rsp_if.state_count);
          mismatches++;
        end else begin
          if (rsp_if.state_count !== expected_bins_q[0].state_count) begin
            $error("state_count: expected %0d, got %0d",
                   expected_bins_q[0].state_count, rsp_if.state_count);
            mismatches++;
          end
          if (rsp_if.read_index !== expected_bins_q[0].read_index) begin
            $error("read_index: expected %0d, got %0d",
                   expected_bins_q[0].read_index, rsp_if.read_index);
            mismatches++;
          end
          if (rsp_if.overflowed !== expected_bins_q[0].overflowed) begin
            $error("overflowed: expected %0d, got %0d",
                   expected_bins_q[0].overflowed, rsp_if.overflowed);
            mismatches++;
          end
          void'(expected_bins_q.pop_front());
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("vibrational_state_count_top verification failed");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    cycle_count     = 0;
    mismatches      = 0;
    send_idle_pct   = 20;
    recv_idle_pct   = 72;
    shadow_step     = GridStepReset;
    shadow_bins     = BinsReset;
    shadow_clear();
    step_set = '{100, 1, 1048575, 0, 1000, 50, 7, 2, 524288, 3, 1048575, 13};
    bins_set = '{1024, 64, 16, 64, 0, 2047, 33, 2, 1023, 1025, 1, 200};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset register values: table edges, a shift of
    // one, halves rounded up, zero shift, a shift past the table, the last
    // reachable shift, an ignored request code and a clear.
    queue_request(OP_READ, '0, '0);
    queue_request(OP_READ, '0, AddrW'(GridSize - 1));
    queue_request(OP_ADD, 20'd100, '0);
    queue_request(OP_READ, '0, 10'd0);
    queue_request(OP_READ, '0, 10'd1);
    queue_request(OP_READ, 20'hFFFFF, AddrW'(GridSize - 1));
    queue_request(OP_ADD, 20'd50, '0);
    queue_request(OP_READ, '0, 10'd2);
    queue_request(OP_ADD, 20'd49, '0);
    queue_request(OP_READ, '0, 10'd2);
    queue_request(OP_ADD, 20'hFFFFF, 10'h3FF);
    queue_request(OP_ADD, 20'd0, '0);
    queue_request(OP_NONE, 20'hFFFFF, 10'h3FF);
    queue_request(OP_READ, '0, 10'h3FF);
    queue_request(OP_ADD, 20'd150, '0);
    queue_request(OP_READ, '0, 10'd3);
    queue_request(OP_ADD, 20'd102349, '0);
    queue_request(OP_READ, '0, 10'h3FF);
    queue_request(OP_CLEAR, 20'hFFFFF, 10'h3FF);
    queue_request(OP_READ, '0, 10'd0);
    queue_request(OP_READ, '0, 10'd5);

    // Random part: four register settings under each idling pattern.
    for (int s = 0; s < NumSettings; s++) begin
      drain();
      if (s == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 20;
      end else if (s == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_GRID_STEP, CfgDataW'(step_set[s]));
      write_reg(CFG_BINS, CfgDataW'(bins_set[s]));

      // Repeated zero-shift doubling from a fresh table drives bin 0 past the
      // top of the count range, so the sticky flag gets set.
      if (s == 1 || s == 2) begin
        queue_request(OP_CLEAR, '0, '0);
        for (int k = 0; k < SatDoublings; k++) begin
          queue_request(OP_ADD, zero_shift_frequency(), pick_bin());
          if (k % 16 == 15 || k >= SatDoublings - 3)
            queue_request(OP_READ, pick_frequency(), pick_bin());
        end
        queue_request(OP_READ, '0, '0);
      end

      for (int k = 0; k < RandPerSetting; k++) begin
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
          queue_request(OP_CLEAR, pick_frequency(), pick_bin());
        else if (pick < 55)
          queue_request(OP_ADD, pick_frequency(), pick_bin());
        else if (pick < 95)
          queue_request(OP_READ, pick_frequency(), pick_bin());
        else
          queue_request(OP_NONE, pick_frequency(), pick_bin());
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("vibrational_state_count_top verification clean");
    end else begin
      $display("vibrational_state_count_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vsc_pkg.sv
rtl/vsc_if.sv
rtl/vsc_ram.sv
rtl/vsc_div.sv
rtl/vibrational_state_count_top.sv
sim/tb.sv
